FILE: design/radial_force_field_update_macros.svh
// Assertion macros for the radial force field update block.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef RADIAL_FORCE_FIELD_UPDATE_MACROS_SVH
`define RADIAL_FORCE_FIELD_UPDATE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RFFU_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("radial force field: implication check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RFFU_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("radial force field: next-cycle check failed");

`endif

FILE: design/rffu_pkg.sv
// Shared types, widths and constants of the radial force field update block.
// No dependencies; imported by every cell and by the top level.
package rffu_pkg;

  localparam int unsigned DATA_W       = 24;  // Q15.8 positions and velocities
  localparam int unsigned DIFF_W       = 25;  // exact position differences
  localparam int unsigned MAG_W        = 23;  // radius, strength, force, distance
  localparam int unsigned STEP_W       = 16;  // Q0.16 time step
  localparam int unsigned DIST2_W      = 50;  // squared distance
  localparam int unsigned ROOT_W       = 51;  // square root working register
  localparam int unsigned DIST_W       = 25;  // full square root result
  localparam int unsigned PROD_W       = 46;  // dividend of the long division
  localparam int unsigned SUM_W        = 26;  // base plus step before saturation
  localparam int unsigned SQRT_STEPS   = 25;
  localparam int unsigned DIV_STEPS    = 23;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_W     = 52;
  localparam int unsigned ANGLE_W      = 26;  // degrees with 16 fraction bits
  localparam int unsigned HEAD_W       = 17;  // degrees Q8.8
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [HEAD_W:0] HEAD_LIM = 18'd46080;
  localparam logic [MAG_W-1:0] REACH_RESET = 23'd256;
  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 26'sd5898240;

  // Arc tangent of 2^-i in degrees, 16 fraction bits.
  localparam logic [ANGLE_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
    26'd2949120, 26'd1740967, 26'd919879, 26'd466945,
    26'd234379,  26'd117304,  26'd58666,  26'd29335,
    26'd14668,   26'd7334,    26'd3667,   26'd1833,
    26'd917,     26'd458,     26'd229,    26'd115
  };

  typedef enum logic [1:0] {
    KIND_SHIP   = 2'd0,
    KIND_BULLET = 2'd1,
    KIND_MINE   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_X = 3'd0,
    CFG_CENTRE_Y = 3'd1,
    CFG_REACH    = 3'd2,
    CFG_PEAK     = 3'd3,
    CFG_REPEL    = 3'd4
  } cfg_idx_e;

  // Per-entity data that travels alongside the arithmetic through the chain.
  typedef struct packed {
    kind_e                    kind;
    logic                     hit;
    logic                     zero;
    logic signed [DATA_W-1:0] base_x;
    logic signed [DATA_W-1:0] base_y;
    logic signed [DIFF_W-1:0] ux;
    logic signed [DIFF_W-1:0] uy;
    logic [STEP_W-1:0]        step;
    logic [MAG_W-1:0]         dist_mag;
    logic [MAG_W-1:0]         force_mag;
    logic signed [HEAD_W-1:0] heading;
  } side_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] lo;
    logic [MAG_W-1:0] quo;
    logic [MAG_W-1:0] den;
  } div_t;

endpackage

FILE: design/rffu_sqrt_cell.sv
// One step of the digit-by-digit integer square root.
// Depends on rffu_pkg; chained by the top level, one cell per result bit.
module rffu_sqrt_cell import rffu_pkg::*; #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  side_t              side_i,
  input  logic [DIST2_W-1:0] n_i,
  input  logic [ROOT_W-1:0]  r_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [DIST2_W-1:0] n_o,
  output logic [ROOT_W-1:0]  r_o
);

  localparam logic [ROOT_W-1:0] BitVal = {{(ROOT_W-1){1'b0}}, 1'b1} << (2 * BIT_POS);

  logic [ROOT_W-1:0]  trial;
  logic               fits;
  logic [DIST2_W-1:0] n_d;
  logic [ROOT_W-1:0]  r_d;

  // Try to set this bit of the root against the remaining radicand.
  always_comb begin
    trial = r_i + BitVal;
    fits  = {1'b0, n_i} >= trial;
    n_d   = fits ? (n_i - trial[DIST2_W-1:0]) : n_i;
    r_d   = fits ? ((r_i >> 1) + BitVal) : (r_i >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    n_o    <= n_d;
    r_o    <= r_d;
  end

endmodule

FILE: design/rffu_div_cell.sv
// One quotient bit of a restoring long division, for one or more lanes.
// Depends on rffu_pkg; chained by the top level, one cell per quotient bit.
module rffu_div_cell import rffu_pkg::*; #(
  parameter int unsigned LANES = 1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  side_t side_i,
  input  div_t  lane_i [LANES],
  output logic  valid_o,
  output side_t side_o,
  output div_t  lane_o [LANES]
);

  div_t lane_d [LANES];

  // Shift in the next dividend bit and subtract the divisor where it fits.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [MAG_W:0] part;
    logic [MAG_W:0] diff;
    logic           ge;

    always_comb begin
      part = {lane_i[l].rem, lane_i[l].lo[MAG_W-1]};
      diff = part - {1'b0, lane_i[l].den};
      ge   = part >= {1'b0, lane_i[l].den};
      lane_d[l].rem = ge ? diff[MAG_W-1:0] : part[MAG_W-1:0];
      lane_d[l].lo  = {lane_i[l].lo[MAG_W-2:0], 1'b0};
      lane_d[l].quo = {lane_i[l].quo[MAG_W-2:0], ge};
      lane_d[l].den = lane_i[l].den;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    lane_o <= lane_d;
  end

endmodule

FILE: design/rffu_cordic_cell.sv
// One vectoring rotation of the heading CORDIC.
// Depends on rffu_pkg for widths and the arc tangent table.
module rffu_cordic_cell import rffu_pkg::*; #(
  parameter int unsigned ITER = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  side_t                      side_i,
  input  logic signed [CORDIC_W-1:0] x_i,
  input  logic signed [CORDIC_W-1:0] y_i,
  input  logic signed [ANGLE_W-1:0]  z_i,
  output logic                       valid_o,
  output side_t                      side_o,
  output logic signed [CORDIC_W-1:0] x_o,
  output logic signed [CORDIC_W-1:0] y_o,
  output logic signed [ANGLE_W-1:0]  z_o
);

  localparam logic signed [CORDIC_W-1:0] RoundAdj =
    ({{(CORDIC_W-1){1'b0}}, 1'b1} << ITER) - {{(CORDIC_W-1){1'b0}}, 1'b1};
  localparam logic signed [ANGLE_W-1:0] Angle = ATAN_TBL[ITER];

  logic signed [CORDIC_W-1:0] xs, ys, x_d, y_d;
  logic signed [ANGLE_W-1:0]  z_d;

  // Shifts truncate toward zero; rotate toward the x axis.
  always_comb begin
    xs  = (x_i < 0) ? ((x_i + RoundAdj) >>> ITER) : (x_i >>> ITER);
    ys  = (y_i < 0) ? ((y_i + RoundAdj) >>> ITER) : (y_i >>> ITER);
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (y_i > 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Angle;
    end else if (y_i < 0) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    x_o    <= x_d;
    y_o    <= y_d;
    z_o    <= z_d;
  end

endmodule

FILE: design/radial_force_field_update.sv
// Radial force field update: one entity transaction per clock.
// A new transaction is taken every cycle; busy stays low, done_o strobes each result.
// The cell chains hold 25 square root, 23 + 23 divider and 16 CORDIC cells.
// Reset clears the configuration to its defaults and empties the pipeline.
// Depends on rffu_pkg, the three cell modules and radial_force_field_update_macros.svh.
`include "radial_force_field_update_macros.svh"

module radial_force_field_update import rffu_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [DATA_W-1:0]           cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind_i,
  input  logic signed [DATA_W-1:0]    pos_x_i,
  input  logic signed [DATA_W-1:0]    pos_y_i,
  input  logic signed [DATA_W-1:0]    vel_x_i,
  input  logic signed [DATA_W-1:0]    vel_y_i,
  input  logic [STEP_W-1:0]           time_step_i,
  output logic                        done_o,
  output logic                        affected_o,
  output logic signed [DATA_W-1:0]    out_x_o,
  output logic signed [DATA_W-1:0]    out_y_o,
  output logic signed [HEAD_W-1:0]    heading_o,
  output logic [MAG_W-1:0]            speed_o
);

  // Configuration registers.
  logic signed [DATA_W-1:0] centre_x_q, centre_y_q;
  logic [MAG_W-1:0]         reach_q, peak_q;
  logic                     repel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      reach_q    <= REACH_RESET;
      peak_q     <= '0;
      repel_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTRE_X: centre_x_q <= cfg_data_i;
        CFG_CENTRE_Y: centre_y_q <= cfg_data_i;
        CFG_REACH:    reach_q    <= cfg_data_i[MAG_W-1:0];
        CFG_PEAK:     peak_q     <= cfg_data_i[MAG_W-1:0];
        CFG_REPEL:    repel_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Stage 1: take the transaction, form the direction vector.
  logic                     v1_q;
  side_t                    side1_q;
  logic signed [DIFF_W-1:0] dx, dy;
  side_t                    side1_d;

  always_comb begin
    dx = {pos_x_i[DATA_W-1], pos_x_i} - {centre_x_q[DATA_W-1], centre_x_q};
    dy = {pos_y_i[DATA_W-1], pos_y_i} - {centre_y_q[DATA_W-1], centre_y_q};
    side1_d           = '0;
    side1_d.kind      = kind_e'(kind_i);
    side1_d.base_x    = (kind_e'(kind_i) == KIND_SHIP) ? vel_x_i : pos_x_i;
    side1_d.base_y    = (kind_e'(kind_i) == KIND_SHIP) ? vel_y_i : pos_y_i;
    side1_d.ux        = repel_q ? dx : -dx;
    side1_d.uy        = repel_q ? dy : -dy;
    side1_d.step      = time_step_i;
  end

  // Stage 2: squared distance.
  logic                      v2_q;
  side_t                     side2_q;
  logic [DIST2_W-1:0]        d2_q;
  logic signed [DIST2_W-1:0] sq_x, sq_y;

  assign sq_x = side1_q.ux * side1_q.ux;
  assign sq_y = side1_q.uy * side1_q.uy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= side1_d;
    side2_q <= side1_q;
    d2_q    <= sq_x + sq_y;
  end

  // Square root chain.
  logic               sq_v    [SQRT_STEPS+1];
  side_t              sq_side [SQRT_STEPS+1];
  logic [DIST2_W-1:0] sq_n    [SQRT_STEPS+1];
  logic [ROOT_W-1:0]  sq_r    [SQRT_STEPS+1];

  assign sq_v[0]    = v2_q;
  assign sq_side[0] = side2_q;
  assign sq_n[0]    = d2_q;
  assign sq_r[0]    = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rffu_sqrt_cell #(.BIT_POS(SQRT_STEPS - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[k]),
      .side_i  (sq_side[k]),
      .n_i     (sq_n[k]),
      .r_i     (sq_r[k]),
      .valid_o (sq_v[k+1]),
      .side_o  (sq_side[k+1]),
      .n_o     (sq_n[k+1]),
      .r_o     (sq_r[k+1])
    );
  end

  // Stage 3: radius test and force numerator.
  logic              v3_q;
  side_t             side3_q, side3_d;
  div_t              fin_q, fin_d;
  logic [DIST_W-1:0] root;
  logic [PROD_W-1:0] fnum;

  always_comb begin
    root             = sq_r[SQRT_STEPS][DIST_W-1:0];
    side3_d          = sq_side[SQRT_STEPS];
    side3_d.hit      = root < {2'b00, reach_q};
    side3_d.zero     = root == '0;
    side3_d.dist_mag = root[MAG_W-1:0];
    fnum         = side3_d.hit ? (peak_q * (reach_q - root[MAG_W-1:0])) : '0;
    fin_d.rem    = fnum[PROD_W-1:MAG_W];
    fin_d.lo     = fnum[MAG_W-1:0];
    fin_d.quo    = '0;
    fin_d.den    = side3_d.hit ? reach_q : {{(MAG_W-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side3_d;
    fin_q   <= fin_d;
  end

  // Force divider chain.
  logic  fd_v    [DIV_STEPS+1];
  side_t fd_side [DIV_STEPS+1];
  div_t  fd_lane [DIV_STEPS+1][1];

  assign fd_v[0]       = v3_q;
  assign fd_side[0]    = side3_q;
  assign fd_lane[0][0] = fin_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_fdiv
    rffu_div_cell #(.LANES(1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (fd_v[k]),
      .side_i  (fd_side[k]),
      .lane_i  (fd_lane[k]),
      .valid_o (fd_v[k+1]),
      .side_o  (fd_side[k+1]),
      .lane_o  (fd_lane[k+1])
    );
  end

  // Stage 4: store the force, rotate the direction into the right half plane.
  logic                       v4_q;
  side_t                      side4_q, side4_d;
  logic signed [CORDIC_W-1:0] cx_d, cy_d, sx, sy;
  logic signed [ANGLE_W-1:0]  cz_d;
  logic signed [CORDIC_W-1:0] cx_q, cy_q;
  logic signed [ANGLE_W-1:0]  cz_q;

  always_comb begin
    side4_d           = fd_side[DIV_STEPS];
    side4_d.force_mag = side4_d.hit ? fd_lane[DIV_STEPS][0].quo : '0;
    sx = side4_d.hit ? (CORDIC_W'(side4_d.ux) <<< 24) : '0;
    sy = side4_d.hit ? (CORDIC_W'(side4_d.uy) <<< 24) : '0;
    cx_d = sx;
    cy_d = sy;
    cz_d = '0;
    if (sx < 0) begin
      if (sy >= 0) begin
        cx_d = sy;
        cy_d = -sx;
        cz_d = QUARTER_TURN;
      end else begin
        cx_d = -sy;
        cy_d = sx;
        cz_d = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= fd_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    side4_q <= side4_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
  end

  // CORDIC chain.
  logic                       cd_v    [CORDIC_STEPS+1];
  side_t                      cd_side [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] cd_x    [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] cd_y    [CORDIC_STEPS+1];
  logic signed [ANGLE_W-1:0]  cd_z    [CORDIC_STEPS+1];

  assign cd_v[0]    = v4_q;
  assign cd_side[0] = side4_q;
  assign cd_x[0]    = cx_q;
  assign cd_y[0]    = cy_q;
  assign cd_z[0]    = cz_q;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    rffu_cordic_cell #(.ITER(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cd_v[k]),
      .side_i  (cd_side[k]),
      .x_i     (cd_x[k]),
      .y_i     (cd_y[k]),
      .z_i     (cd_z[k]),
      .valid_o (cd_v[k+1]),
      .side_o  (cd_side[k+1]),
      .x_o     (cd_x[k+1]),
      .y_o     (cd_y[k+1]),
      .z_o     (cd_z[k+1])
    );
  end

  // Stage 5: round the heading, scale the direction by the force.
  logic                      v5_q;
  side_t                     side5_q, side5_d;
  logic signed [ANGLE_W-1:0] zf;
  logic [ANGLE_W-1:0]        zmag;
  logic [HEAD_W:0]           hmag;
  logic [MAG_W-1:0]          mag_x, mag_y;
  logic [DIFF_W-1:0]         abs_x, abs_y;
  logic [PROD_W-1:0]         pfx_q, pfy_q;
  logic                      push_en5;

  always_comb begin
    side5_d  = cd_side[CORDIC_STEPS];
    zf       = cd_z[CORDIC_STEPS];
    zmag     = (zf < 0) ? -zf : zf;
    hmag     = zmag[ANGLE_W-1:8] + {{HEAD_W{1'b0}}, zmag[7]};
    if (hmag > HEAD_LIM) begin
      hmag = HEAD_LIM;
    end
    side5_d.heading = (zf < 0) ? -hmag[HEAD_W-1:0] : hmag[HEAD_W-1:0];
    push_en5 = side5_d.hit && !side5_d.zero;
    abs_x    = (side5_d.ux < 0) ? -side5_d.ux : side5_d.ux;
    abs_y    = (side5_d.uy < 0) ? -side5_d.uy : side5_d.uy;
    mag_x    = push_en5 ? abs_x[MAG_W-1:0] : '0;
    mag_y    = push_en5 ? abs_y[MAG_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= cd_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    side5_q <= side5_d;
    pfx_q   <= mag_x * side5_d.force_mag;
    pfy_q   <= mag_y * side5_d.force_mag;
  end

  // Stage 6: scale by the time step and set up the push dividers.
  logic                       v6_q;
  side_t                      side6_q;
  div_t                       pin_q [2];
  logic [PROD_W+STEP_W-1:0]   ptx, pty;
  logic [PROD_W-1:0]          nx, ny;
  logic                       push_en6;
  logic [MAG_W-1:0]           pden;

  always_comb begin
    push_en6 = side5_q.hit && !side5_q.zero;
    ptx  = pfx_q * side5_q.step;
    pty  = pfy_q * side5_q.step;
    nx   = push_en6 ? ptx[PROD_W+STEP_W-1:STEP_W] : '0;
    ny   = push_en6 ? pty[PROD_W+STEP_W-1:STEP_W] : '0;
    pden = push_en6 ? side5_q.dist_mag : {{(MAG_W-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side6_q      <= side5_q;
    pin_q[0].rem <= nx[PROD_W-1:MAG_W];
    pin_q[0].lo  <= nx[MAG_W-1:0];
    pin_q[0].quo <= '0;
    pin_q[0].den <= pden;
    pin_q[1].rem <= ny[PROD_W-1:MAG_W];
    pin_q[1].lo  <= ny[MAG_W-1:0];
    pin_q[1].quo <= '0;
    pin_q[1].den <= pden;
  end

  // Push divider chain, x and y lanes side by side.
  logic  pd_v    [DIV_STEPS+1];
  side_t pd_side [DIV_STEPS+1];
  div_t  pd_lane [DIV_STEPS+1][2];

  assign pd_v[0]    = v6_q;
  assign pd_side[0] = side6_q;
  assign pd_lane[0] = pin_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_pdiv
    rffu_div_cell #(.LANES(2)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pd_v[k]),
      .side_i  (pd_side[k]),
      .lane_i  (pd_lane[k]),
      .valid_o (pd_v[k+1]),
      .side_o  (pd_side[k+1]),
      .lane_o  (pd_lane[k+1])
    );
  end

  // Stage 7: apply the push with saturation and build the result.
  side_t                    so;
  logic signed [SUM_W-1:0]  add_x, add_y, sum_x, sum_y;
  logic signed [DATA_W-1:0] sat_x, sat_y;
  logic                     aff_d;
  logic signed [DATA_W-1:0] ox_d, oy_d;
  logic signed [HEAD_W-1:0] head_d;
  logic [MAG_W-1:0]         spd_d;

  always_comb begin
    so    = pd_side[DIV_STEPS];
    add_x = {3'b000, pd_lane[DIV_STEPS][0].quo};
    add_y = {3'b000, pd_lane[DIV_STEPS][1].quo};
    if (so.ux < 0) begin
      add_x = -add_x;
    end
    if (so.uy < 0) begin
      add_y = -add_y;
    end
    if (!so.hit || so.zero) begin
      add_x = '0;
      add_y = '0;
    end
    sum_x = SUM_W'(so.base_x) + add_x;
    sum_y = SUM_W'(so.base_y) + add_y;
    sat_x = (sum_x > SUM_W'(24'sh7FFFFF)) ? 24'sh7FFFFF :
            (sum_x < -SUM_W'(26'sh800000)) ? 24'sh800000 : sum_x[DATA_W-1:0];
    sat_y = (sum_y > SUM_W'(24'sh7FFFFF)) ? 24'sh7FFFFF :
            (sum_y < -SUM_W'(26'sh800000)) ? 24'sh800000 : sum_y[DATA_W-1:0];
    aff_d  = so.hit;
    ox_d   = '0;
    oy_d   = '0;
    head_d = '0;
    spd_d  = '0;
    case (so.kind)
      KIND_SHIP, KIND_MINE: begin
        ox_d = sat_x;
        oy_d = sat_y;
      end
      KIND_BULLET: begin
        head_d = so.hit ? so.heading : '0;
        spd_d  = so.hit ? so.force_mag : '0;
      end
      default: begin
        aff_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= pd_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    affected_o <= aff_d;
    out_x_o    <= ox_d;
    out_y_o    <= oy_d;
    heading_o  <= head_d;
    speed_o    <= spd_d;
  end

  // Checks on the pipeline and the result.
  `RFFU_ASSERT_IMP(a_heading_range, done_o, (heading_o <= 17'sd46080) && (heading_o >= -17'sd46080))
  `RFFU_ASSERT_IMP(a_unaffected_quiet, done_o && !affected_o, (heading_o == '0) && (speed_o == '0))
  `RFFU_ASSERT_IMP(a_force_rem, fd_v[DIV_STEPS], fd_lane[DIV_STEPS][0].rem < fd_lane[DIV_STEPS][0].den)
  `RFFU_ASSERT_NXT(a_done_follows, pd_v[DIV_STEPS], done_o)

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the radial force field update block.
// Depends on rffu_pkg and the radial_force_field_update top level.
`timescale 1ns / 1ps

module testbench;
  import rffu_pkg::*;

  localparam int LATENCY = 94;
  localparam int N_RANDOM = 600;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [DATA_W-1:0]        cfg_data_i = '0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               kind_i = '0;
  logic signed [DATA_W-1:0] pos_x_i = '0;
  logic signed [DATA_W-1:0] pos_y_i = '0;
  logic signed [DATA_W-1:0] vel_x_i = '0;
  logic signed [DATA_W-1:0] vel_y_i = '0;
  logic [STEP_W-1:0]        time_step_i = '0;
  logic                     done_o;
  logic                     affected_o;
  logic signed [DATA_W-1:0] out_x_o;
  logic signed [DATA_W-1:0] out_y_o;
  logic signed [HEAD_W-1:0] heading_o;
  logic [MAG_W-1:0]         speed_o;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic [STEP_W-1:0]        step;
  } entity_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] ox;
    logic signed [DATA_W-1:0] oy;
    logic signed [HEAD_W-1:0] head;
    logic [MAG_W-1:0]         spd;
  } update_t;

  // Directed row: an entity and, where known by inspection, its result.
  typedef struct {
    entity_t ent;
    bit      typed;
    update_t res;
  } row_t;

  // Shadow copy of the field configuration.
  longint fld_cx, fld_cy, fld_reach, fld_peak;
  bit     fld_repel;

  update_t expected_q[$];
  int      mismatches = 0;
  bit      quiet_run = 1'b0;

  radial_force_field_update uut (.*);

  always #10 clk_i = ~clk_i;

  function automatic longint trunc_shift(longint v, int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sh4000_0000_0000_0000;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // The step product is formed at 128 bits so that it cannot overflow.
  function automatic longint nudge(longint v, longint frc, longint stp, longint dst);
    logic [127:0] num, den;
    longint q;
    num = 128'(v < 0 ? -v : v) * 128'(frc) * 128'(stp);
    den = 128'(dst) << 16;
    q = longint'(num / den);
    return v < 0 ? -q : q;
  endfunction

  // Bullet heading by CORDIC vectoring in degrees with 16 fraction bits, returned with 8.
  function automatic longint bearing(longint x, longint y);
    longint atan_q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115};
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * (64'sd1 << 24);
    y = y * (64'sd1 << 24);
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = trunc_shift(x, i);
      ys = trunc_shift(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_q16[i];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= atan_q16[i];
      end
    end
    if (z >= 0) z = (z + 128) / 256;
    else z = -((-z + 128) / 256);
    if (z > 46080) z = 46080;
    if (z < -46080) z = -46080;
    return z;
  endfunction

  function automatic update_t field_update(entity_t e);
    update_t r;
    longint dx, dy, dst, frc, ux, uy, bx, by;
    bit hit;
    r = '0;
    if (e.kind == KIND_NONE) return r;
    dx = longint'(e.px) - fld_cx;
    dy = longint'(e.py) - fld_cy;
    dst = int_sqrt(dx * dx + dy * dy);
    hit = dst < fld_reach;
    frc = 0; ux = 0; uy = 0;
    if (hit) begin
      frc = (fld_peak * (fld_reach - dst)) / fld_reach;
      ux = fld_repel ? dx : -dx;
      uy = fld_repel ? dy : -dy;
    end
    if (e.kind == KIND_SHIP || e.kind == KIND_MINE) begin
      bx = (e.kind == KIND_SHIP) ? longint'(e.vx) : longint'(e.px);
      by = (e.kind == KIND_SHIP) ? longint'(e.vy) : longint'(e.py);
      if (hit && dst != 0) begin
        bx += nudge(ux, frc, e.step, dst);
        by += nudge(uy, frc, e.step, dst);
      end
      r.ox = DATA_W'(clamp24(bx));
      r.oy = DATA_W'(clamp24(by));
    end else if (hit) begin
      r.head = HEAD_W'(bearing(ux, uy));
      r.spd = MAG_W'(frc);
    end
    r.hit = hit;
    return r;
  endfunction

  // One register write; the caller drops the write enable after the last one.
  task automatic write_reg(cfg_idx_e idx, longint val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[DATA_W-1:0];
    @(negedge clk_i);
    case (idx)
      CFG_CENTRE_X: fld_cx = longint'(signed'(val[DATA_W-1:0]));
      CFG_CENTRE_Y: fld_cy = longint'(signed'(val[DATA_W-1:0]));
      CFG_REACH:    fld_reach = val & 64'h7FFFFF;
      CFG_PEAK:     fld_peak = val & 64'h7FFFFF;
      CFG_REPEL:    fld_repel = val[0];
      default: ;
    endcase
  endtask

  task automatic set_field(longint cx, longint cy, longint rc, longint pk, bit rp);
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_REACH, rc);
    write_reg(CFG_PEAK, pk);
    write_reg(CFG_REPEL, rp);
    cfg_we_i <= 1'b0;
  endtask

  // Stop sending and let the pipeline drain before touching the configuration.
  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Drive one entity transaction, optionally with a random gap in front.
  task automatic send(entity_t e, update_t res);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start       <= 1'b1;
    kind_i      <= e.kind;
    pos_x_i     <= e.px;
    pos_y_i     <= e.py;
    vel_x_i     <= e.vx;
    vel_y_i     <= e.vy;
    time_step_i <= e.step;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(res);
    @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] any24();
    return DATA_W'($urandom);
  endfunction

  // Random entity; most land near the centre so the field acts on them.
  function automatic entity_t random_entity();
    entity_t e;
    longint span;
    e.kind = $urandom_range(0, 19) == 0 ? 2'(KIND_NONE) : 2'($urandom_range(0, 2));
    span = fld_reach + 2;
    if ($urandom_range(0, 4) != 0 && span < 64'sd4000000) begin
      e.px = DATA_W'(clamp24(fld_cx + $signed($urandom_range(0, 2 * span)) - span));
      e.py = DATA_W'(clamp24(fld_cy + $signed($urandom_range(0, 2 * span)) - span));
    end else begin
      e.px = any24();
      e.py = any24();
    end
    if ($urandom_range(0, 3) == 0) begin
      e.vx = $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
      e.vy = $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
    end else begin
      e.vx = any24();
      e.vy = any24();
    end
    e.step = $urandom_range(0, 5) == 0 ? 16'hFFFF : STEP_W'($urandom);
    return e;
  endfunction

  // Check each result strobe against the oldest expectation.
  always @(posedge clk_i) begin
    update_t exp_r, got;
    if (rst_ni && done_o) begin
      got = '{affected_o, out_x_o, out_y_o, heading_o, speed_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", exp_r, got);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    row_t    rows[$];
    row_t    rw;
    entity_t e;
    int      n;
    fld_cx = 0; fld_cy = 0; fld_reach = 256; fld_peak = 0; fld_repel = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows; typed results only where plain from inspection.
    // After reset the strength is zero: a ship at the centre keeps its velocity.
    rows.push_back('{'{KIND_SHIP, 24'sd0, 24'sd0, 24'sh7FFFFF, -24'sh800000, 16'hFFFF},
                     1, '{1'b1, 24'sh7FFFFF, -24'sh800000, '0, '0}});
    // Far outside the radius: a mine passes through unaffected.
    rows.push_back('{'{KIND_MINE, -24'sh800000, 24'sh7FFFFF, 24'sd5, 24'sd5, 16'd0},
                     1, '{1'b0, -24'sh800000, 24'sh7FFFFF, '0, '0}});
    // Kind three gives an all-zero result.
    rows.push_back('{'{KIND_NONE, 24'sd3, 24'sd4, 24'sd9, 24'sd9, 16'd9},
                     1, '0});
    rows.push_back('{'{KIND_BULLET, 24'sd300, 24'sd0, 24'sd0, 24'sd0, 16'd0},
                     1, '0});
    foreach (rows[i])
      send(rows[i].ent, rows[i].typed ? rows[i].res : field_update(rows[i].ent));
    drain();

    // Strong field: zero distance, two quadrants, the edge of the radius.
    rows.delete();
    set_field(-24'sd1000, 24'sd2000, 64'sd1024, 64'sh7FFFFF, 1'b0);
    for (int k = 0; k < 3; k++) begin
      rw.typed = 0;
      rw.ent = '{k[1:0], -24'sd1000, 24'sd2000, 24'sd77, -24'sd77, 16'hFFFF};
      rows.push_back(rw);
      rw.ent = '{k[1:0], -24'sd700, 24'sd2400, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF};
      rows.push_back(rw);
      rw.ent = '{k[1:0], -24'sd1500, 24'sd1700, -24'sh800000, -24'sh800000, 16'hFFFF};
      rows.push_back(rw);
      rw.ent = '{k[1:0], -24'sd1000, 24'sd977, 24'sd0, 24'sd0, 16'h8000};
      rows.push_back(rw);
      rw.ent = '{k[1:0], -24'sd2023, 24'sd2000, 24'sd1, 24'sd1, 16'd1};
      rows.push_back(rw);
    end
    foreach (rows[i])
      send(rows[i].ent, rows[i].typed ? rows[i].res : field_update(rows[i].ent));
    drain();
    set_field(24'sd0, 24'sd0, 64'sd1, 64'sd1, 1'b1);
    e = '{KIND_SHIP, 24'sd0, 24'sd0, 24'sd1, 24'sd2, 16'd3};
    send(e, field_update(e));
    drain();

    // Random phases across several field settings, extremes included.
    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_field(24'sh7FFFFF, -24'sh800000, 64'h7FFFFF, 64'h7FFFFF, 1'b1);
        1: set_field(-24'sh800000, 24'sh7FFFFF, 64'sd1, 64'sd0, 1'b0);
        default: set_field($signed(any24()) >>> $urandom_range(0, 12),
                           $signed(any24()) >>> $urandom_range(0, 12),
                           $urandom_range(1, 1 << $urandom_range(1, 22)),
                           $urandom_range(0, 23'h7FFFFF), $urandom_range(0, 1));
      endcase
      quiet_run = (ph == 5);
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        e = random_entity();
        send(e, field_update(e));
        n++;
      end
      drain();
    end

    start <= 1'b0;
    @(negedge clk_i);
    for (int w = 0; w < 100 * LATENCY && expected_q.size() != 0; w++) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: radial_force_field_update.f
+incdir+design
design/rffu_pkg.sv
design/rffu_sqrt_cell.sv
design/rffu_div_cell.sv
design/rffu_cordic_cell.sv
design/radial_force_field_update.sv
bench/testbench.sv
